// File: design/tlfk_pkg.sv
// Package with the shared types, constants and sine table function of the two-link arm block.
package tlfk_pkg;

	localparam int unsigned SINE_TABLE_BITS_DEF = 10;
	localparam int unsigned ANGLE_BITS_DEF      = 16;

	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned RATE_W     = 16;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned POS_W      = 18;
	localparam int unsigned VEL_W      = 22;
	localparam int unsigned TRIG_W     = 16;
	localparam int unsigned TERM_W     = 17;
	localparam int unsigned CFG_ADDR_W = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_UPPER_LEN = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOWER_LEN = 4'd1;

	localparam logic [LEN_W-1:0] UPPER_LEN_RST = 16'd4096;
	localparam logic [LEN_W-1:0] LOWER_LEN_RST = 16'd4096;

	localparam logic [63:0] PI_HALF_Q30 = 64'h0000_0000_6487_ED51;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// One quarter-wave entry, sin(pi*idx/2^(bits+1)) in Q1.15, from a truncated Q30 series.
	function automatic logic [15:0] sine_entry(input int unsigned bits, input int unsigned idx);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] v;
		x    = (PI_HALF_Q30 * 64'(idx)) >> bits;
		x2   = (x * x) >> 30;
		term = ((x * x2) >> 30) / 64'd6;
		acc  = x - term;
		term = ((term * x2) >> 30) / 64'd20;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd42;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd72;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd110;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd156;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd210;
		acc  = acc - term;
		v    = (acc + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

// File: design/tlfk_if.sv
// Stream and configuration channel interfaces of the two-link arm block.
interface tlfk_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [tlfk_pkg::ANGLE_W-1:0]     shoulder_angle;
	logic signed [tlfk_pkg::ANGLE_W-1:0]     elbow_angle;
	logic signed [tlfk_pkg::RATE_W-1:0]      shoulder_rate;
	logic signed [tlfk_pkg::RATE_W-1:0]      elbow_rate;

	modport source (output valid, shoulder_angle, elbow_angle, shoulder_rate, elbow_rate,
		input ready);
	modport sink (input valid, shoulder_angle, elbow_angle, shoulder_rate, elbow_rate,
		output ready);
endinterface

interface tlfk_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [tlfk_pkg::POS_W-1:0]   pos_x;
	logic signed [tlfk_pkg::POS_W-1:0]   pos_y;
	logic signed [tlfk_pkg::VEL_W-1:0]   vel_x;
	logic signed [tlfk_pkg::VEL_W-1:0]   vel_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface tlfk_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tlfk_pkg::CFG_ADDR_W-1:0]   addr;
	logic [tlfk_pkg::LEN_W-1:0]        data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: design/tlfk_trig.sv
// Sine and cosine of one angle from a quarter-wave table, two pipeline stages.
module tlfk_trig #(
	parameter int unsigned SINE_TABLE_BITS = tlfk_pkg::SINE_TABLE_BITS_DEF,
	parameter int unsigned ANGLE_BITS      = tlfk_pkg::ANGLE_BITS_DEF
) (
	input  logic                                  clk,
	input  tlfk_pkg::pipe_en_t                    en,
	input  logic [ANGLE_BITS-1:0]                 angle,
	output logic signed [tlfk_pkg::TRIG_W-1:0]    sin_s2,
	output logic signed [tlfk_pkg::TRIG_W-1:0]    cos_s2
);

	localparam int unsigned QTR   = 1 << SINE_TABLE_BITS;
	localparam int          SHIFT = int'(ANGLE_BITS) - 2 - int'(SINE_TABLE_BITS);

	logic [14:0]                rom_w [QTR+1];
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS:0]   idx_lo;
	logic [SINE_TABLE_BITS:0]   idx_hi;
	logic [14:0]                t_lo_s1;
	logic [14:0]                t_hi_s1;
	logic [1:0]                 quad_s1;
	logic [1:0]                 quad_cos;
	logic [14:0]                t_sin;
	logic [14:0]                t_cos;

	for (genvar g = 0; g <= QTR; g++) begin : g_rom
		assign rom_w[g] = 15'(tlfk_pkg::sine_entry(SINE_TABLE_BITS, g));
	end

	if (SHIFT >= 0) begin : g_idx_trunc
		assign idx = angle[ANGLE_BITS-3 -: SINE_TABLE_BITS];
	end else begin : g_idx_pad
		assign idx = {angle[ANGLE_BITS-3:0], {(-SHIFT){1'b0}}};
	end

	assign idx_lo = {1'b0, idx};
	assign idx_hi = (SINE_TABLE_BITS+1)'(QTR) - idx_lo;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_lo_s1 <= rom_w[idx_lo];
			t_hi_s1 <= rom_w[idx_hi];
			quad_s1 <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
		end
	end

	// Cosine is the sine one quadrant further on.
	always_comb begin
		quad_cos = quad_s1 + 2'd1;
		t_sin    = quad_s1[0] ? t_hi_s1 : t_lo_s1;
		t_cos    = quad_cos[0] ? t_hi_s1 : t_lo_s1;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sin_s2 <= quad_s1[1] ? -$signed({1'b0, t_sin}) : $signed({1'b0, t_sin});
			cos_s2 <= quad_cos[1] ? -$signed({1'b0, t_cos}) : $signed({1'b0, t_cos});
		end
	end

endmodule

// File: design/tlfk_pos.sv
// Link-length products and end-effector position, pipeline stages three and four.
module tlfk_pos (
	input  logic                                  clk,
	input  tlfk_pkg::pipe_en_t                    en,
	input  logic [tlfk_pkg::LEN_W-1:0]            upper_len,
	input  logic [tlfk_pkg::LEN_W-1:0]            lower_len,
	input  logic signed [tlfk_pkg::TRIG_W-1:0]    sin1,
	input  logic signed [tlfk_pkg::TRIG_W-1:0]    cos1,
	input  logic signed [tlfk_pkg::TRIG_W-1:0]    sin12,
	input  logic signed [tlfk_pkg::TRIG_W-1:0]    cos12,
	output logic signed [tlfk_pkg::POS_W-1:0]     px_s4,
	output logic signed [tlfk_pkg::POS_W-1:0]     py_s4,
	output logic signed [tlfk_pkg::TERM_W-1:0]    p12c_s4,
	output logic signed [tlfk_pkg::TERM_W-1:0]    p12s_s4
);

	logic signed [32:0]                    prod_1c;
	logic signed [32:0]                    prod_1s;
	logic signed [32:0]                    prod_12c;
	logic signed [32:0]                    prod_12s;
	logic signed [tlfk_pkg::TERM_W-1:0]    p1c_s3;
	logic signed [tlfk_pkg::TERM_W-1:0]    p1s_s3;
	logic signed [tlfk_pkg::TERM_W-1:0]    p12c_s3;
	logic signed [tlfk_pkg::TERM_W-1:0]    p12s_s3;

	always_comb begin
		prod_1c  = $signed({1'b0, upper_len}) * cos1;
		prod_1s  = $signed({1'b0, upper_len}) * sin1;
		prod_12c = $signed({1'b0, lower_len}) * cos12;
		prod_12s = $signed({1'b0, lower_len}) * sin12;
	end

	// The magnitude of a length times a Q1.15 value stays below 2^31.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			p1c_s3  <= prod_1c[31:15];
			p1s_s3  <= prod_1s[31:15];
			p12c_s3 <= prod_12c[31:15];
			p12s_s3 <= prod_12s[31:15];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			px_s4   <= {p1c_s3[16], p1c_s3} + {p12c_s3[16], p12c_s3};
			py_s4   <= {p1s_s3[16], p1s_s3} + {p12s_s3[16], p12s_s3};
			p12c_s4 <= p12c_s3;
			p12s_s4 <= p12s_s3;
		end
	end

endmodule

// File: design/tlfk_vel.sv
// Joint-rate products and end-effector velocity, pipeline stages five and six.
module tlfk_vel (
	input  logic                                  clk,
	input  tlfk_pkg::pipe_en_t                    en,
	input  logic signed [tlfk_pkg::RATE_W-1:0]    w1,
	input  logic signed [tlfk_pkg::RATE_W-1:0]    w2,
	input  logic signed [tlfk_pkg::POS_W-1:0]     px,
	input  logic signed [tlfk_pkg::POS_W-1:0]     py,
	input  logic signed [tlfk_pkg::TERM_W-1:0]    p12c,
	input  logic signed [tlfk_pkg::TERM_W-1:0]    p12s,
	output logic signed [tlfk_pkg::POS_W-1:0]     pos_x_s6,
	output logic signed [tlfk_pkg::POS_W-1:0]     pos_y_s6,
	output logic signed [tlfk_pkg::VEL_W-1:0]     vel_x_s6,
	output logic signed [tlfk_pkg::VEL_W-1:0]     vel_y_s6
);

	logic signed [16:0]                  nw1;
	logic signed [16:0]                  nw2;
	logic signed [34:0]                  prod_vx1;
	logic signed [33:0]                  prod_vx2;
	logic signed [33:0]                  prod_vy1;
	logic signed [32:0]                  prod_vy2;
	logic signed [22:0]                  vx1_s5;
	logic signed [22:0]                  vx2_s5;
	logic signed [22:0]                  vy1_s5;
	logic signed [22:0]                  vy2_s5;
	logic signed [tlfk_pkg::POS_W-1:0]   px_s5;
	logic signed [tlfk_pkg::POS_W-1:0]   py_s5;
	logic signed [22:0]                  sum_x;
	logic signed [22:0]                  sum_y;

	// The x terms are negated before the product so that the shift rounds as required.
	always_comb begin
		nw1      = -$signed({w1[15], w1});
		nw2      = -$signed({w2[15], w2});
		prod_vx1 = nw1 * py;
		prod_vx2 = nw2 * p12s;
		prod_vy1 = w1 * px;
		prod_vy2 = w2 * p12c;
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			vx1_s5 <= prod_vx1[34:12];
			vx2_s5 <= {prod_vx2[33], prod_vx2[33:12]};
			vy1_s5 <= {prod_vy1[33], prod_vy1[33:12]};
			vy2_s5 <= {{2{prod_vy2[32]}}, prod_vy2[32:12]};
			px_s5  <= px;
			py_s5  <= py;
		end
	end

	always_comb begin
		sum_x = vx1_s5 + vx2_s5;
		sum_y = vy1_s5 + vy2_s5;
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			pos_x_s6 <= px_s5;
			pos_y_s6 <= py_s5;
			vel_x_s6 <= sum_x[21:0];
			vel_y_s6 <= sum_y[21:0];
		end
	end

endmodule

// File: design/two_link_arm_forward_kinematics.sv
// Top level of the two-link planar arm forward kinematics pipeline.
// The block takes one joint sample per cycle when the result side does not stall, and
// returns its end-effector position and velocity in order: stages one and two read the
// quarter-wave sine table (a registered two-port ROM per angle) and fold the quadrant,
// stage three multiplies the link lengths, stage four adds the positions, stage five
// multiplies the joint rates and stage six sums the velocities into the output register.
// Each stage holds its item while the stage after it is full and stalled, so empty stages
// still take new samples. Link lengths are written through the configuration channel,
// which never stalls; the user must write them only while no item is in flight (unchecked).
module two_link_arm_forward_kinematics #(
	parameter int unsigned SINE_TABLE_BITS = tlfk_pkg::SINE_TABLE_BITS_DEF,
	parameter int unsigned ANGLE_BITS      = tlfk_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	tlfk_in_if.sink            joint,
	tlfk_out_if.source         tip,
	tlfk_cfg_if.sink           cfg
);

	tlfk_pkg::pipe_en_t                  en;
	logic                                v_s1;
	logic                                v_s2;
	logic                                v_s3;
	logic                                v_s4;
	logic                                v_s5;
	logic                                v_s6;
	logic [tlfk_pkg::LEN_W-1:0]          upper_len_q;
	logic [tlfk_pkg::LEN_W-1:0]          lower_len_q;
	logic [ANGLE_BITS-1:0]               a1;
	logic [ANGLE_BITS-1:0]               a2;
	logic [ANGLE_BITS-1:0]               a12;
	logic signed [tlfk_pkg::RATE_W-1:0]  w1_s1;
	logic signed [tlfk_pkg::RATE_W-1:0]  w2_s1;
	logic signed [tlfk_pkg::RATE_W-1:0]  w1_s2;
	logic signed [tlfk_pkg::RATE_W-1:0]  w2_s2;
	logic signed [tlfk_pkg::RATE_W-1:0]  w1_s3;
	logic signed [tlfk_pkg::RATE_W-1:0]  w2_s3;
	logic signed [tlfk_pkg::RATE_W-1:0]  w1_s4;
	logic signed [tlfk_pkg::RATE_W-1:0]  w2_s4;
	logic signed [tlfk_pkg::TRIG_W-1:0]  sin1_s2;
	logic signed [tlfk_pkg::TRIG_W-1:0]  cos1_s2;
	logic signed [tlfk_pkg::TRIG_W-1:0]  sin12_s2;
	logic signed [tlfk_pkg::TRIG_W-1:0]  cos12_s2;
	logic signed [tlfk_pkg::POS_W-1:0]   px_s4;
	logic signed [tlfk_pkg::POS_W-1:0]   py_s4;
	logic signed [tlfk_pkg::TERM_W-1:0]  p12c_s4;
	logic signed [tlfk_pkg::TERM_W-1:0]  p12s_s4;

	always_comb begin
		en.s6 = !v_s6 || tip.ready;
		en.s5 = !v_s5 || en.s6;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign joint.ready = en.s1;
	assign tip.valid   = v_s6;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= joint.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_len_q <= tlfk_pkg::UPPER_LEN_RST;
			lower_len_q <= tlfk_pkg::LOWER_LEN_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				tlfk_pkg::REG_UPPER_LEN: upper_len_q <= cfg.data;
				tlfk_pkg::REG_LOWER_LEN: lower_len_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Angles are sign-extended or truncated to the angle width; the elbow sum wraps.
	always_comb begin
		a1  = ANGLE_BITS'(joint.shoulder_angle);
		a2  = ANGLE_BITS'(joint.elbow_angle);
		a12 = a1 + a2;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			w1_s1 <= joint.shoulder_rate;
			w2_s1 <= joint.elbow_rate;
		end
		if (en.s2) begin
			w1_s2 <= w1_s1;
			w2_s2 <= w2_s1;
		end
		if (en.s3) begin
			w1_s3 <= w1_s2;
			w2_s3 <= w2_s2;
		end
		if (en.s4) begin
			w1_s4 <= w1_s3;
			w2_s4 <= w2_s3;
		end
	end

	tlfk_trig #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.ANGLE_BITS      (ANGLE_BITS)
	) u_trig_shoulder (
		.clk    (clk),
		.en     (en),
		.angle  (a1),
		.sin_s2 (sin1_s2),
		.cos_s2 (cos1_s2)
	);

	tlfk_trig #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.ANGLE_BITS      (ANGLE_BITS)
	) u_trig_elbow (
		.clk    (clk),
		.en     (en),
		.angle  (a12),
		.sin_s2 (sin12_s2),
		.cos_s2 (cos12_s2)
	);

	tlfk_pos u_pos (
		.clk       (clk),
		.en        (en),
		.upper_len (upper_len_q),
		.lower_len (lower_len_q),
		.sin1      (sin1_s2),
		.cos1      (cos1_s2),
		.sin12     (sin12_s2),
		.cos12     (cos12_s2),
		.px_s4     (px_s4),
		.py_s4     (py_s4),
		.p12c_s4   (p12c_s4),
		.p12s_s4   (p12s_s4)
	);

	tlfk_vel u_vel (
		.clk      (clk),
		.en       (en),
		.w1       (w1_s4),
		.w2       (w2_s4),
		.px       (px_s4),
		.py       (py_s4),
		.p12c     (p12c_s4),
		.p12s     (p12s_s4),
		.pos_x_s6 (tip.pos_x),
		.pos_y_s6 (tip.pos_y),
		.vel_x_s6 (tip.vel_x),
		.vel_y_s6 (tip.vel_y)
	);

endmodule

// File: design/tlfk_checker.sv
// Port-level assertion checker of the two-link arm block and its bind statement.
module tlfk_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 joint_valid,
	input logic                                 joint_ready,
	input logic                                 tip_valid,
	input logic                                 tip_ready,
	input logic signed [tlfk_pkg::POS_W-1:0]    tip_pos_x,
	input logic signed [tlfk_pkg::POS_W-1:0]    tip_pos_y,
	input logic signed [tlfk_pkg::VEL_W-1:0]    tip_vel_x,
	input logic signed [tlfk_pkg::VEL_W-1:0]    tip_vel_y
);

	logic [5:0] xfer_q;
	logic [4:0] rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_q <= '0;
			rdy_q  <= '0;
		end else begin
			xfer_q <= {xfer_q[4:0], joint_valid && joint_ready};
			rdy_q  <= {rdy_q[3:0], tip_ready};
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tip_valid && !tip_ready |=> tip_valid)
		else $error("result valid dropped before its transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tip_valid && !tip_ready |=> $stable(tip_pos_x) && $stable(tip_pos_y)
			&& $stable(tip_vel_x) && $stable(tip_vel_y))
		else $error("stalled result changed");

	// An empty output register means no stage can be stalled.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!tip_valid |-> joint_ready)
		else $error("input stalled while the output is empty");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_q[5] && (rdy_q == 5'h1f) |-> tip_valid)
		else $error("result missing six cycles after an unstalled transfer");

endmodule

bind two_link_arm_forward_kinematics tlfk_checker u_tlfk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.joint_valid (joint.valid),
	.joint_ready (joint.ready),
	.tip_valid   (tip.valid),
	.tip_ready   (tip.ready),
	.tip_pos_x   (tip.pos_x),
	.tip_pos_y   (tip.pos_y),
	.tip_vel_x   (tip.vel_x),
	.tip_vel_y   (tip.vel_y)
);

// File: test/tb.sv
// Self-checking testbench for the two-link arm forward kinematics block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;

	localparam int STB    = tlfk_pkg::SINE_TABLE_BITS_DEF;
	localparam int ABITS  = tlfk_pkg::ANGLE_BITS_DEF;
	localparam int QTR    = 1 << STB;
	localparam int SETTLE = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	localparam int ANGLE_W    = tlfk_pkg::ANGLE_W;
	localparam int RATE_W     = tlfk_pkg::RATE_W;
	localparam int LEN_W      = tlfk_pkg::LEN_W;
	localparam int POS_W      = tlfk_pkg::POS_W;
	localparam int VEL_W      = tlfk_pkg::VEL_W;
	localparam int CFG_ADDR_W = tlfk_pkg::CFG_ADDR_W;

	localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 4'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TOP   = 4'd15;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] shoulder_angle;
		logic signed [ANGLE_W-1:0] elbow_angle;
		logic signed [RATE_W-1:0]  shoulder_rate;
		logic signed [RATE_W-1:0]  elbow_rate;
	} joint_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
	} tip_t;

	typedef enum logic [1:0] {STEP_JOINT, STEP_WRITE, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		joint_t                joint;
		logic [CFG_ADDR_W-1:0] addr;
		logic [LEN_W-1:0]      data;
	} step_t;

	logic clk;
	logic arst_n;

	tlfk_in_if  joint();
	tlfk_out_if tip();
	tlfk_cfg_if cfg();

	two_link_arm_forward_kinematics u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.joint  (joint),
		.tip    (tip),
		.cfg    (cfg)
	);

	longint qsine [0:QTR];
	step_t plan [$];
	tip_t tip_due [$];
	logic [LEN_W-1:0] upper_len;
	logic [LEN_W-1:0] lower_len;
	int plan_joints;
	int joints_sent;
	int tips_seen;
	int mismatches;
	int settle_left;
	int quiet;

	always #2 clk = ~clk;

	function automatic void fill_qsine();
		u64_t ang;
		u64_t ang_sq;
		u64_t term;
		u64_t sum;
		u64_t rnd;
		for (int i = 0; i <= QTR; i++) begin
			ang = (u64_t'(tlfk_pkg::PI_HALF_Q30) * u64_t'(i)) >> STB;
			ang_sq = (ang * ang) >> 30;
			term = ang;
			sum = ang;
			for (int k = 1; k <= 7; k++) begin
				term = ((term * ang_sq) >> 30) / u64_t'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			rnd = (sum + 64'd16384) >> 15;
			if (rnd > 64'd32767) begin
				rnd = 64'd32767;
			end
			qsine[i] = longint'(rnd);
		end
	endfunction

	// A quarter offset of one turns the sine lookup into a cosine lookup.
	function automatic longint wave(input logic [ABITS-1:0] ang, input int quarter);
		logic [1:0] quad;
		logic [ABITS-3:0] rest;
		int dsh;
		int idx;
		longint t;
		quad = ang[ABITS-1 -: 2] + 2'(quarter);
		rest = ang[ABITS-3:0];
		dsh = ABITS - 2 - STB;
		if (dsh >= 0) begin
			idx = int'(rest >> dsh);
		end else begin
			idx = int'(rest) << (-dsh);
		end
		idx = idx & (QTR - 1);
		t = quad[0] ? qsine[QTR - idx] : qsine[idx];
		return quad[1] ? -t : t;
	endfunction

	function automatic tip_t arm_tip_of(input joint_t j, input logic [LEN_W-1:0] l1_raw,
		input logic [LEN_W-1:0] l2_raw);
		logic [ABITS-1:0] a1;
		logic [ABITS-1:0] a12;
		longint l1;
		longint l2;
		longint w1;
		longint w2;
		longint p1c;
		longint p1s;
		longint p12c;
		longint p12s;
		longint px;
		longint py;
		longint vx;
		longint vy;
		tip_t r;
		a1 = ABITS'(longint'(j.shoulder_angle));
		a12 = a1 + ABITS'(longint'(j.elbow_angle));
		l1 = longint'(l1_raw);
		l2 = longint'(l2_raw);
		w1 = longint'(j.shoulder_rate);
		w2 = longint'(j.elbow_rate);
		p1c = (l1 * wave(a1, 1)) >>> 15;
		p1s = (l1 * wave(a1, 0)) >>> 15;
		p12c = (l2 * wave(a12, 1)) >>> 15;
		p12s = (l2 * wave(a12, 0)) >>> 15;
		px = p1c + p12c;
		py = p1s + p12s;
		vx = ((-(w1 * py)) >>> 12) + ((-(w2 * p12s)) >>> 12);
		vy = ((w1 * px) >>> 12) + ((w2 * p12c) >>> 12);
		r.pos_x = POS_W'(px);
		r.pos_y = POS_W'(py);
		r.vel_x = VEL_W'(vx);
		r.vel_y = VEL_W'(vy);
		return r;
	endfunction

	task automatic add_joint(input int sa, input int ea, input int sr, input int er);
		step_t st;
		st.kind = STEP_JOINT;
		st.joint.shoulder_angle = ANGLE_W'(sa);
		st.joint.elbow_angle = ANGLE_W'(ea);
		st.joint.shoulder_rate = RATE_W'(sr);
		st.joint.elbow_rate = RATE_W'(er);
		st.addr = '0;
		st.data = '0;
		plan.push_back(st);
		plan_joints++;
	endtask

	task automatic add_write(input logic [CFG_ADDR_W-1:0] addr, input logic [LEN_W-1:0] data);
		step_t st;
		st.kind = STEP_WRITE;
		st.joint = '0;
		st.addr = addr;
		st.data = data;
		plan.push_back(st);
	endtask

	task automatic add_drain();
		step_t st;
		st.kind = STEP_DRAIN;
		st.joint = '0;
		st.addr = '0;
		st.data = '0;
		plan.push_back(st);
	endtask

	// Angles near a quadrant boundary are picked often, since the table fold changes there.
	function automatic logic signed [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(3))
			0: begin
				return ANGLE_W'(($urandom_range(3) << 14) + $urandom_range(31) - 16);
			end
			default: begin
				return ANGLE_W'($urandom);
			end
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(4))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return 16'd4096;
			end
			default: begin
				return LEN_W'($urandom);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		joint_t acc;
		int gap_pct;
		logic joint_go;
		logic write_go;
		if (!arst_n) begin
			joint.valid <= 1'b0;
			joint.shoulder_angle <= '0;
			joint.elbow_angle <= '0;
			joint.shoulder_rate <= '0;
			joint.elbow_rate <= '0;
			cfg.valid <= 1'b0;
			cfg.addr <= '0;
			cfg.data <= '0;
			upper_len = tlfk_pkg::UPPER_LEN_RST;
			lower_len = tlfk_pkg::LOWER_LEN_RST;
			settle_left = 0;
		end else begin
			if (joint.valid && joint.ready) begin
				acc.shoulder_angle = joint.shoulder_angle;
				acc.elbow_angle = joint.elbow_angle;
				acc.shoulder_rate = joint.shoulder_rate;
				acc.elbow_rate = joint.elbow_rate;
				tip_due.push_back(arm_tip_of(acc, upper_len, lower_len));
				joints_sent++;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					tlfk_pkg::REG_UPPER_LEN: begin
						upper_len = cfg.data;
					end
					tlfk_pkg::REG_LOWER_LEN: begin
						lower_len = cfg.data;
					end
					default: begin
					end
				endcase
			end
			if (!(joint.valid && !joint.ready) && !(cfg.valid && !cfg.ready)) begin
				joint_go = 1'b0;
				write_go = 1'b0;
				if (joints_sent < plan_joints / 3) begin
					gap_pct = 38;
				end else if (joints_sent < 2 * plan_joints / 3) begin
					gap_pct = 49;
				end else begin
					gap_pct = 0;
				end
				if (settle_left > 0) begin
					settle_left--;
				end else if (plan.size() > 0) begin
					case (plan[0].kind)
						STEP_JOINT: begin
							if ($urandom_range(99) >= gap_pct) begin
								acc = plan[0].joint;
								void'(plan.pop_front());
								joint_go = 1'b1;
								joint.shoulder_angle <= acc.shoulder_angle;
								joint.elbow_angle <= acc.elbow_angle;
								joint.shoulder_rate <= acc.shoulder_rate;
								joint.elbow_rate <= acc.elbow_rate;
							end
						end
						STEP_WRITE: begin
							write_go = 1'b1;
							cfg.addr <= plan[0].addr;
							cfg.data <= plan[0].data;
							void'(plan.pop_front());
						end
						default: begin
							if (tip_due.size() == 0) begin
								void'(plan.pop_front());
								settle_left = SETTLE;
							end
						end
					endcase
				end
				joint.valid <= joint_go;
				cfg.valid <= write_go;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		tip_t seen;
		tip_t due;
		int stall_pct;
		if (!arst_n) begin
			tip.ready <= 1'b0;
		end else begin
			if (tip.valid && tip.ready) begin
				seen.pos_x = tip.pos_x;
				seen.pos_y = tip.pos_y;
				seen.vel_x = tip.vel_x;
				seen.vel_y = tip.vel_y;
				tips_seen++;
				if (tip_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result with none expected: x=%0d y=%0d vx=%0d vy=%0d",
							$time, seen.pos_x, seen.pos_y, seen.vel_x, seen.vel_y);
					end
				end else begin
					due = tip_due.pop_front();
					if (seen.pos_x !== due.pos_x || seen.pos_y !== due.pos_y ||
						seen.vel_x !== due.vel_x || seen.vel_y !== due.vel_y) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected x=%0d y=%0d vx=%0d vy=%0d, got x=%0d y=%0d vx=%0d vy=%0d",
								$time, due.pos_x, due.pos_y, due.vel_x, due.vel_y,
								seen.pos_x, seen.pos_y, seen.vel_x, seen.vel_y);
						end
					end
				end
			end
			if (tips_seen < plan_joints / 3) begin
				stall_pct = 49;
			end else if (tips_seen < 2 * plan_joints / 3) begin
				stall_pct = 38;
			end else begin
				stall_pct = 0;
			end
			tip.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((joint.valid && joint.ready) || (tip.valid && tip.ready) ||
				(cfg.valid && cfg.ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		joint.valid = 1'b0;
		joint.shoulder_angle = '0;
		joint.elbow_angle = '0;
		joint.shoulder_rate = '0;
		joint.elbow_rate = '0;
		tip.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = '0;
		cfg.data = '0;
		plan_joints = 0;
		joints_sent = 0;
		tips_seen = 0;
		mismatches = 0;
		quiet = 0;
		fill_qsine();

		// Reset lengths: quadrant boundaries, elbow wrap and the truncated index bits.
		add_joint(0, 0, 0, 0);
		add_joint(16384, 0, 4096, 0);
		add_joint(-32768, 0, 0, 4096);
		add_joint(-16384, 16384, -4096, 4096);
		add_joint(32767, 32767, 32767, 32767);
		add_joint(-32768, -32768, -32768, -32768);
		add_joint(8192, -1, -1, 1);
		add_joint(-1, 1, 100, -100);
		add_joint(15, 16, 12345, -12345);
		add_joint(16383, 1, -7, 7);

		// Longest links with the largest rates give the widest velocities.
		add_drain();
		add_write(tlfk_pkg::REG_UPPER_LEN, 16'hFFFF);
		add_write(tlfk_pkg::REG_LOWER_LEN, 16'hFFFF);
		add_write(REG_SPARE, 16'h5A5A);
		add_joint(0, 0, 32767, 32767);
		add_joint(0, 0, -32768, -32768);
		add_joint(16384, 0, -32768, 32767);
		add_joint(-16384, 0, 32767, -32768);
		add_joint(8192, 0, -32768, -32768);
		add_joint(-24576, 0, 32767, 32767);

		add_drain();
		add_write(tlfk_pkg::REG_UPPER_LEN, 16'h0000);
		add_write(REG_TOP, 16'hA5A5);
		add_joint(0, 0, 32767, -32768);
		add_joint(16384, 16384, -32768, 32767);

		add_drain();
		add_write(tlfk_pkg::REG_UPPER_LEN, 16'hFFFF);
		add_write(tlfk_pkg::REG_LOWER_LEN, 16'h0000);
		add_joint(-8192, 24576, 32767, 32767);
		add_joint(24576, -8192, -32768, -32768);

		for (int s = 0; s < 8; s++) begin
			add_drain();
			add_write(tlfk_pkg::REG_UPPER_LEN, pick_len());
			add_write(tlfk_pkg::REG_LOWER_LEN, pick_len());
			for (int n = 0; n < 116; n++) begin
				if ($urandom_range(39) == 0) begin
					add_drain();
				end
				add_joint(pick_angle(), pick_angle(), int'($urandom), int'($urandom));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (plan.size() > 0 || joint.valid || cfg.valid || tip_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && tip_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
